@@ rtl/kts_pkg.sv @@
package kts_pkg;

   // Defaults for the top-level parameters.
   localparam int ROT_ENTRIES_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 18;

   // Fixed field widths.
   localparam int OP_BITS        = 2;
   localparam int ROT_IDX_BITS   = 6;
   localparam int COEF_IDX_BITS  = 4;
   localparam int GAIN_BITS      = 18;
   localparam int AXIS_BITS      = 3;

   // Fixed-point formats.
   localparam int GAIN_FRAC = 14;
   localparam int COEF_FRAC = 16;

   // Matrix shape.
   localparam int MAT_DIM  = 3;
   localparam int MAT_SIZE = 9;
   localparam int ROW_BITS = 2;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLOSE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_ROTATE,
      KIND_PASS,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ROW_BITS-1:0] col;
   } entry_ctl_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ROWS,
      BACK_DONE
   } back_state_type;

endpackage

@@ rtl/kts_channels.sv @@
interface kts_req_if import kts_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic        [OP_BITS-1:0]       op;
   logic        [ROT_IDX_BITS-1:0]  rot_index;
   logic        [COEF_IDX_BITS-1:0] coef_index;
   logic signed [COEF_BITS-1:0]     coef_value;
   logic                            rotate;
   logic        [AXIS_BITS-1:0]     axis_present;
   logic signed [SAMPLE_BITS-1:0]   kx_sample;
   logic signed [SAMPLE_BITS-1:0]   ky_sample;
   logic signed [SAMPLE_BITS-1:0]   kz_sample;
   logic signed [GAIN_BITS-1:0]     x_gain;
   logic signed [GAIN_BITS-1:0]     y_gain;
   logic signed [GAIN_BITS-1:0]     z_gain;

   modport source (
      output valid, op, rot_index, coef_index, coef_value, rotate, axis_present,
             kx_sample, ky_sample, kz_sample, x_gain, y_gain, z_gain,
      input  ready
   );
   modport sink (
      input  valid, op, rot_index, coef_index, coef_value, rotate, axis_present,
             kx_sample, ky_sample, kz_sample, x_gain, y_gain, z_gain,
      output ready
   );
endinterface

interface kts_rsp_if import kts_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_out;
   logic signed [SAMPLE_BITS-1:0] y_out;
   logic signed [SAMPLE_BITS-1:0] z_out;
   logic                          is_report;
   logic        [AXIS_BITS-1:0]   axis_mask;
   logic                          clipped;

   modport source (
      output valid, x_out, y_out, z_out, is_report, axis_mask, clipped,
      input  ready
   );
   modport sink (
      input  valid, x_out, y_out, z_out, is_report, axis_mask, clipped,
      output ready
   );
endinterface

@@ rtl/kts_ram.sv @@
module kts_ram #(
   parameter int WIDTH     = 18,
   parameter int DEPTH     = 192,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/kts_front.sv @@
module kts_front import kts_pkg::*; #(
   parameter int ROT_ENTRIES = ROT_ENTRIES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF,
   parameter int ADDR_BITS   = 8,
   parameter int SCALED_BITS = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC
) (
   input  logic                          clock,
   input  logic                          reset,
   kts_req_if.sink                       req_chan,
   output logic                          head_valid,
   input  logic                          pop,
   output entry_ctl_type                 head_ctl,
   output logic        [ADDR_BITS-1:0]   head_addr,
   output logic signed [COEF_BITS-1:0]   head_coef,
   output logic signed [SCALED_BITS-1:0] head_scaled [MAT_DIM]
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(2 ** (GAIN_FRAC - 1));

   // Coefficients are stored one column per memory, indexed by entry and row.
   function automatic logic [ROW_BITS-1:0] coef_row(input logic [COEF_IDX_BITS-1:0] ci);
      logic [ROW_BITS-1:0] r;
      case (ci)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] coef_col(input logic [COEF_IDX_BITS-1:0] ci);
      logic [ROW_BITS-1:0] c;
      case (ci)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;

   entry_ctl_type                 q_ctl_ff    [QUEUE_DEPTH];
   logic        [ADDR_BITS-1:0]   q_addr_ff   [QUEUE_DEPTH];
   logic signed [COEF_BITS-1:0]   q_coef_ff   [QUEUE_DEPTH];
   logic signed [SCALED_BITS-1:0] q_scaled_ff [QUEUE_DEPTH][MAT_DIM];

   logic                          accept;
   logic                          keep;
   logic                          rot_ok;
   logic                          ci_ok;
   logic                          push;
   logic                          take;
   entry_ctl_type                 new_ctl;
   logic        [ADDR_BITS-1:0]   base_addr;
   logic        [ADDR_BITS-1:0]   new_addr;
   logic signed [SAMPLE_BITS-1:0] k_in   [MAT_DIM];
   logic signed [GAIN_BITS-1:0]   g_in   [MAT_DIM];
   logic signed [PROD_BITS-1:0]   prod   [MAT_DIM];
   logic signed [SCALED_BITS-1:0] scaled [MAT_DIM];

   assign req_chan.ready = (count_ff != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != '0);
   assign take           = pop && head_valid;

   assign k_in[0] = req_chan.kx_sample;
   assign k_in[1] = req_chan.ky_sample;
   assign k_in[2] = req_chan.kz_sample;
   assign g_in[0] = req_chan.x_gain;
   assign g_in[1] = req_chan.y_gain;
   assign g_in[2] = req_chan.z_gain;

   always_comb begin
      rot_ok    = (32'(req_chan.rot_index) < ROT_ENTRIES);
      ci_ok     = (req_chan.coef_index <= COEF_IDX_BITS'(MAT_SIZE - 1));
      base_addr = ADDR_BITS'({req_chan.rot_index, 1'b0}) + ADDR_BITS'(req_chan.rot_index);
      new_addr  = base_addr;
      new_ctl.col  = coef_col(req_chan.coef_index);
      new_ctl.kind = KIND_CLOSE;
      keep         = 1'b0;
      case (req_chan.op)
         OP_LOAD: begin
            new_ctl.kind = KIND_LOAD;
            new_addr     = base_addr + ADDR_BITS'(coef_row(req_chan.coef_index));
            keep         = rot_ok && ci_ok;
         end
         OP_SAMPLE: begin
            // A rotation entry beyond the table passes the axes straight through.
            new_ctl.kind = (req_chan.rotate && rot_ok) ? KIND_ROTATE : KIND_PASS;
            keep         = 1'b1;
         end
         OP_CLOSE: begin
            new_ctl.kind = KIND_CLOSE;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push = accept && keep;
   end

   // Scale each present axis by its gain, rounding half up.
   always_comb begin
      for (int a = 0; a < MAT_DIM; a++) begin
         prod[a]   = PROD_BITS'(k_in[a]) * PROD_BITS'(g_in[a]) + ROUND_HALF;
         scaled[a] = req_chan.axis_present[a] ? prod[a][PROD_BITS-1:GAIN_FRAC] : '0;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ctl_ff[wr_ptr_ff]  <= new_ctl;
         q_addr_ff[wr_ptr_ff] <= new_addr;
         q_coef_ff[wr_ptr_ff] <= req_chan.coef_value;
         for (int a = 0; a < MAT_DIM; a++) begin
            q_scaled_ff[wr_ptr_ff][a] <= scaled[a];
         end
      end
   end

   assign head_ctl  = q_ctl_ff[rd_ptr_ff];
   assign head_addr = q_addr_ff[rd_ptr_ff];
   assign head_coef = q_coef_ff[rd_ptr_ff];

   always_comb begin
      for (int a = 0; a < MAT_DIM; a++) begin
         head_scaled[a] = q_scaled_ff[rd_ptr_ff][a];
      end
   end

endmodule

@@ rtl/kts_back.sv @@
module kts_back import kts_pkg::*; #(
   parameter int ROT_ENTRIES = ROT_ENTRIES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF,
   parameter int ADDR_BITS   = 8,
   parameter int SCALED_BITS = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   output logic                          pop,
   input  entry_ctl_type                 head_ctl,
   input  logic        [ADDR_BITS-1:0]   head_addr,
   input  logic signed [COEF_BITS-1:0]   head_coef,
   input  logic signed [SCALED_BITS-1:0] head_scaled [MAT_DIM],
   kts_rsp_if.source                     rsp_chan
);

   localparam int STORE_DEPTH  = ROT_ENTRIES * MAT_DIM;
   localparam int MUL_BITS     = COEF_BITS + SCALED_BITS;
   localparam int SUM_BITS     = MUL_BITS + 2;
   localparam int ROT_BITS     = SUM_BITS - COEF_FRAC;
   localparam int SAT_BITS     = (ROT_BITS > SCALED_BITS) ? ROT_BITS : SCALED_BITS;
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(2 ** (COEF_FRAC - 1));
   localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(MAT_DIM - 1);
   localparam logic [ROW_BITS-1:0] ROW_END  = ROW_BITS'(MAT_DIM);

   // Returns the clip flag above the value clamped to the signed output range.
   function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [SAT_BITS-1:0] v);
      logic [SAT_BITS-SAMPLE_BITS:0] top;
      logic [SAMPLE_BITS:0]          r;
      top = v[SAT_BITS-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         r = {1'b0, v[SAMPLE_BITS-1:0]};
      end else if (v[SAT_BITS-1]) begin
         r = {1'b1, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         r = {1'b1, 1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
      return r;
   endfunction

   back_state_type state_ff, state_in;

   logic        [ROW_BITS-1:0]    iss_ff, iss_in;
   logic                          rdv_ff, rdv_in;
   logic        [ROW_BITS-1:0]    rd_row_ff;
   logic                          prodv_ff, prodv_in;
   logic        [ROW_BITS-1:0]    prod_row_ff;
   logic        [ADDR_BITS-1:0]   base_ff, base_in;
   logic signed [SCALED_BITS-1:0] scaled_ff [MAT_DIM];
   logic signed [SCALED_BITS-1:0] scaled_in [MAT_DIM];
   logic signed [MUL_BITS-1:0]    prod_ff   [MAT_DIM];
   logic signed [MUL_BITS-1:0]    prod_in   [MAT_DIM];
   logic signed [SAMPLE_BITS-1:0] res_ff    [MAT_DIM];
   logic signed [SAMPLE_BITS-1:0] res_in    [MAT_DIM];
   logic        [MAT_DIM-1:0]     clip_ff, clip_in;
   logic                          report_ff, report_in;
   logic        [AXIS_BITS-1:0]   nz_ff, nz_in;

   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                          out_report_ff;
   logic        [AXIS_BITS-1:0]   out_mask_ff;
   logic                          out_clip_ff;

   logic                          issuing;
   logic                          rd_en;
   logic        [ADDR_BITS-1:0]   rd_addr;
   logic        [MAT_DIM-1:0]     wr_en;
   logic signed [COEF_BITS-1:0]   rd_coef [MAT_DIM];
   logic signed [SUM_BITS-1:0]    row_sum;
   logic        [SAMPLE_BITS:0]   row_sat;
   logic        [SAMPLE_BITS:0]   pass_sat [MAT_DIM];
   logic                          out_free;
   logic                          emit;
   logic        [AXIS_BITS-1:0]   res_nz;

   // One memory per matrix column, addressed by entry and row.
   for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
      logic [COEF_BITS-1:0] rd_raw;

      assign wr_en[c]   = pop && (head_ctl.kind == KIND_LOAD) &&
                          (head_ctl.col == ROW_BITS'(c));
      assign rd_coef[c] = $signed(rd_raw);

      kts_ram #(
         .WIDTH     (COEF_BITS),
         .DEPTH     (STORE_DEPTH),
         .ADDR_BITS (ADDR_BITS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[c]),
         .wr_addr (head_addr),
         .wr_data (head_coef),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_raw)
      );
   end

   assign pop      = (state_ff == BACK_IDLE) && head_valid;
   assign issuing  = (state_ff == BACK_ROWS) && (iss_ff != ROW_END);
   assign rd_en    = issuing;
   assign rd_addr  = base_ff + ADDR_BITS'(iss_ff);
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = (state_ff == BACK_DONE) && out_free;

   always_comb begin
      row_sum = ROUND_HALF;
      for (int c = 0; c < MAT_DIM; c++) begin
         prod_in[c] = MUL_BITS'(rd_coef[c]) * MUL_BITS'(scaled_ff[c]);
         row_sum    = row_sum + SUM_BITS'(prod_ff[c]);
      end
      row_sat = saturate(SAT_BITS'($signed(row_sum[SUM_BITS-1:COEF_FRAC])));
      for (int a = 0; a < MAT_DIM; a++) begin
         pass_sat[a] = saturate(SAT_BITS'(head_scaled[a]));
         res_nz[a]   = (res_ff[a] != '0);
      end
   end

   always_comb begin
      state_in  = state_ff;
      iss_in    = iss_ff;
      base_in   = base_ff;
      scaled_in = scaled_ff;
      res_in    = res_ff;
      clip_in   = clip_ff;
      report_in = report_ff;
      nz_in     = nz_ff;
      rdv_in    = issuing;
      prodv_in  = rdv_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop) begin
               case (head_ctl.kind)
                  KIND_ROTATE: begin
                     base_in   = head_addr;
                     scaled_in = head_scaled;
                     iss_in    = '0;
                     report_in = 1'b0;
                     state_in  = BACK_ROWS;
                  end
                  KIND_PASS: begin
                     for (int a = 0; a < MAT_DIM; a++) begin
                        res_in[a]  = pass_sat[a][SAMPLE_BITS-1:0];
                        clip_in[a] = pass_sat[a][SAMPLE_BITS];
                     end
                     report_in = 1'b0;
                     state_in  = BACK_DONE;
                  end
                  KIND_CLOSE: begin
                     for (int a = 0; a < MAT_DIM; a++) begin
                        res_in[a] = '0;
                     end
                     clip_in   = '0;
                     report_in = 1'b1;
                     state_in  = BACK_DONE;
                  end
                  default: begin
                     // A coefficient load is written to the memory this cycle.
                     state_in = BACK_IDLE;
                  end
               endcase
            end
         end
         BACK_ROWS: begin
            if (issuing) begin
               iss_in = iss_ff + 1'b1;
            end
            if (prodv_ff) begin
               for (int a = 0; a < MAT_DIM; a++) begin
                  if (prod_row_ff == ROW_BITS'(a)) begin
                     res_in[a]  = row_sat[SAMPLE_BITS-1:0];
                     clip_in[a] = row_sat[SAMPLE_BITS];
                  end
               end
               if (prod_row_ff == LAST_ROW) begin
                  state_in = BACK_DONE;
               end
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               nz_in    = report_ff ? '0 : (nz_ff | res_nz);
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         iss_ff       <= '0;
         rdv_ff       <= 1'b0;
         prodv_ff     <= 1'b0;
         nz_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rdv_ff       <= rdv_in;
         prodv_ff     <= prodv_in;
         nz_ff        <= nz_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      scaled_ff   <= scaled_in;
      res_ff      <= res_in;
      clip_ff     <= clip_in;
      report_ff   <= report_in;
      rd_row_ff   <= iss_ff;
      prod_row_ff <= rd_row_ff;
      prod_ff     <= prod_in;
      if (emit) begin
         out_x_ff      <= res_ff[0];
         out_y_ff      <= res_ff[1];
         out_z_ff      <= res_ff[2];
         out_report_ff <= report_ff;
         out_mask_ff   <= report_ff ? nz_ff : '0;
         out_clip_ff   <= |clip_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.x_out     = out_x_ff;
   assign rsp_chan.y_out     = out_y_ff;
   assign rsp_chan.z_out     = out_z_ff;
   assign rsp_chan.is_report = out_report_ff;
   assign rsp_chan.axis_mask = out_mask_ff;
   assign rsp_chan.clipped   = out_clip_ff;

endmodule

@@ rtl/kspace_trajectory_scale_rotate.sv @@
// K-space trajectory scaler and rotator. Each request item is a coefficient load, a
// trajectory sample or an encoding-space close. A load writes one signed Q1.16 entry of a
// 3x3 matrix in a table of ROT_ENTRIES matrices and gives no response; loads with a
// coefficient position above 8 or a table index beyond the table are dropped, as is the
// unused operation code. A sample scales each present axis (Q8.15) by its gain (Q3.14)
// with round-half-up, multiplies the three scaled axes by the selected matrix unless
// rotation is off or the index lies beyond the table, rounds again, saturates each axis
// to SAMPLE_BITS and raises clipped if any axis saturated. A close returns the mask of
// axes that produced a nonzero output since the previous close and clears it. A matrix
// must be fully loaded before a sample applies it; unloaded entries read as garbage.
// The front end scales and classifies items and buffers up to two of them, so it keeps
// accepting while the back end works or while a response waits at the output register.
// In the back end the matrix is kept one column per memory, so one row of three
// coefficients is read per cycle, and each row then passes through a multiply stage and
// a sum, round and saturate stage before the response is registered. The back end takes
// no new item until it is through with the last, so the sustained rate is set by that
// three-row read sequence for rotated samples.
module kspace_trajectory_scale_rotate import kts_pkg::*; #(
   parameter int ROT_ENTRIES = ROT_ENTRIES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kts_req_if.sink   req_chan,
   kts_rsp_if.source rsp_chan
);

   // The table holds three rows of each matrix per column memory.
   localparam int STORE_DEPTH = ROT_ENTRIES * MAT_DIM;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   // Scaled axes keep their full width until the final saturation.
   localparam int SCALED_BITS = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC;

   logic                          head_valid;
   logic                          pop;
   entry_ctl_type                 head_ctl;
   logic        [ADDR_BITS-1:0]   head_addr;
   logic signed [COEF_BITS-1:0]   head_coef;
   logic signed [SCALED_BITS-1:0] head_scaled [MAT_DIM];

   kts_front #(
      .ROT_ENTRIES (ROT_ENTRIES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .SCALED_BITS (SCALED_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .head_valid  (head_valid),
      .pop         (pop),
      .head_ctl    (head_ctl),
      .head_addr   (head_addr),
      .head_coef   (head_coef),
      .head_scaled (head_scaled)
   );

   // The back end executes queued items strictly in order, so a load is always visible
   // to every later sample and a close sees the effect of every earlier sample.
   kts_back #(
      .ROT_ENTRIES (ROT_ENTRIES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .SCALED_BITS (SCALED_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .pop         (pop),
      .head_ctl    (head_ctl),
      .head_addr   (head_addr),
      .head_coef   (head_coef),
      .head_scaled (head_scaled),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ rtl/kts_checker.sv @@
module kts_assertions import kts_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] x_out,
   input logic signed [SAMPLE_BITS-1:0] y_out,
   input logic signed [SAMPLE_BITS-1:0] z_out,
   input logic                          is_report,
   input logic        [AXIS_BITS-1:0]   axis_mask,
   input logic                          clipped
);

   localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // A waiting response item is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped before it was taken");

   // A close report carries only the axis mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_report |->
         x_out == '0 && y_out == '0 && z_out == '0 && !clipped)
      else $error("close report carries sample data");

   // A sample result never carries an axis mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_report |-> axis_mask == '0)
      else $error("sample result carries an axis mask");

   // A clipped sample has at least one axis pinned at a range limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_report && clipped |->
         x_out == OUT_MAX || x_out == OUT_MIN ||
         y_out == OUT_MAX || y_out == OUT_MIN ||
         z_out == OUT_MAX || z_out == OUT_MIN)
      else $error("clipped sample has no saturated axis");

endmodule

bind kspace_trajectory_scale_rotate kts_assertions #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_kts_assertions (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .x_out     (rsp_chan.x_out),
   .y_out     (rsp_chan.y_out),
   .z_out     (rsp_chan.z_out),
   .is_report (rsp_chan.is_report),
   .axis_mask (rsp_chan.axis_mask),
   .clipped   (rsp_chan.clipped)
);

@@ dv/kts_checker.sv @@
`timescale 1ns / 100ps

module kts_checker import kts_pkg::*; (
   input  logic clock,
   input  logic reset,
   kts_req_if   req_mon,
   kts_rsp_if   rsp_mon,
   output int   results_due,
   output int   mismatch_count
);

   localparam int SW         = SAMPLE_BITS_DEF;
   localparam int CW         = COEF_BITS_DEF;
   localparam int STORE_SIZE = ROT_ENTRIES_DEF * MAT_SIZE;
   localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (SW - 1));

   typedef struct {
      logic signed [SW-1:0] x_out;
      logic signed [SW-1:0] y_out;
      logic signed [SW-1:0] z_out;
      logic                 is_report;
      logic [AXIS_BITS-1:0] axis_mask;
      logic                 clipped;
   } traj_result_type;

   logic signed [CW-1:0] coef_table [STORE_SIZE];
   logic [AXIS_BITS-1:0] nonzero_seen;
   traj_result_type      due_results [$];

   // Round half up, i.e. floor((v + 2^(sh-1)) / 2^sh).
   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint saturate(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Expected output of one sample item; also updates the sticky nonzero mask.
   function automatic traj_result_type scale_and_rotate();
      traj_result_type r;
      longint          k [MAT_DIM];
      longint          g [MAT_DIM];
      longint          scaled [MAT_DIM];
      longint          axis_val [MAT_DIM];
      longint          acc;
      int              base;
      logic            clip;
      k[0] = longint'(req_mon.kx_sample);
      k[1] = longint'(req_mon.ky_sample);
      k[2] = longint'(req_mon.kz_sample);
      g[0] = longint'(req_mon.x_gain);
      g[1] = longint'(req_mon.y_gain);
      g[2] = longint'(req_mon.z_gain);
      clip = 1'b0;
      base = int'(req_mon.rot_index) * MAT_SIZE;
      for (int a = 0; a < MAT_DIM; a++) begin
         scaled[a] = req_mon.axis_present[a] ? round_shift(k[a] * g[a], GAIN_FRAC) :
                                               longint'(0);
      end
      for (int a = 0; a < MAT_DIM; a++) begin
         if (req_mon.rotate && int'(req_mon.rot_index) < ROT_ENTRIES_DEF) begin
            acc = 0;
            for (int c = 0; c < MAT_DIM; c++) begin
               acc += longint'(coef_table[base + a * MAT_DIM + c]) * scaled[c];
            end
            axis_val[a] = round_shift(acc, COEF_FRAC);
         end else begin
            axis_val[a] = scaled[a];
         end
         if (saturate(axis_val[a]) != axis_val[a]) clip = 1'b1;
         axis_val[a] = saturate(axis_val[a]);
         if (axis_val[a] != 0) nonzero_seen[a] = 1'b1;
      end
      r.x_out     = axis_val[0][SW-1:0];
      r.y_out     = axis_val[1][SW-1:0];
      r.z_out     = axis_val[2][SW-1:0];
      r.is_report = 1'b0;
      r.axis_mask = '0;
      r.clipped   = clip;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      end
   endfunction

   always @(posedge clock) begin : track
      traj_result_type want;
      if (reset) begin
         nonzero_seen   = '0;
         mismatch_count = 0;
         due_results.delete();
      end else begin
         // Results are registered, so one leaving now is never caused by the item
         // accepted at this same edge: compare first, then predict.
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_results.size() == 0) begin
               mismatch_count++;
               $error("result item arrived with no prediction waiting");
            end else begin
               want = due_results.pop_front();
               check_field("x_out", 32'(want.x_out), 32'(rsp_mon.x_out));
               check_field("y_out", 32'(want.y_out), 32'(rsp_mon.y_out));
               check_field("z_out", 32'(want.z_out), 32'(rsp_mon.z_out));
               check_field("is_report", 32'(want.is_report), 32'(rsp_mon.is_report));
               check_field("axis_mask", 32'(want.axis_mask), 32'(rsp_mon.axis_mask));
               check_field("clipped", 32'(want.clipped), 32'(rsp_mon.clipped));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.op)
               OP_LOAD: begin
                  if (int'(req_mon.coef_index) < MAT_SIZE &&
                      int'(req_mon.rot_index) < ROT_ENTRIES_DEF) begin
                     coef_table[int'(req_mon.rot_index) * MAT_SIZE +
                                int'(req_mon.coef_index)] = req_mon.coef_value;
                  end
               end
               OP_SAMPLE: begin
                  want        = scale_and_rotate();
                  due_results = {due_results, want};
               end
               OP_CLOSE: begin
                  want.x_out     = '0;
                  want.y_out     = '0;
                  want.z_out     = '0;
                  want.is_report = 1'b1;
                  want.axis_mask = nonzero_seen;
                  want.clipped   = 1'b0;
                  nonzero_seen   = '0;
                  due_results    = {due_results, want};
               end
               default: begin
               end
            endcase
         end
      end
      results_due = due_results.size();
   end

endmodule

@@ dv/kspace_trajectory_scale_rotate_tb.sv @@
`timescale 1ns / 100ps

module kspace_trajectory_scale_rotate_tb import kts_pkg::*;;

   localparam int SW = SAMPLE_BITS_DEF;
   localparam int CW = COEF_BITS_DEF;

   // Extremes of the signed fields.
   localparam int S_MAX = (1 <<< (SW - 1)) - 1;
   localparam int S_MIN = -(1 <<< (SW - 1));
   localparam int G_MAX = (1 <<< (GAIN_BITS - 1)) - 1;
   localparam int G_MIN = -(1 <<< (GAIN_BITS - 1));
   localparam int C_MAX = (1 <<< (CW - 1)) - 1;
   localparam int C_MIN = -(1 <<< (CW - 1));

   // Unity in the gain format (Q3.14).
   localparam int GAIN_ONE = 1 <<< GAIN_FRAC;
   localparam int COEF_ONE = 1 <<< COEF_FRAC;

   // The one operation code the package leaves unnamed; the block must drop it.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 750;
   localparam int CALM_TAIL    = 100;
   localparam int MODE_SPAN    = 50;
   localparam int DRAIN_SPAN   = 250;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [OP_BITS-1:0]            op;
      logic [ROT_IDX_BITS-1:0]       rot_index;
      logic [COEF_IDX_BITS-1:0]      coef_index;
      logic signed [CW-1:0]          coef_value;
      logic                          rotate;
      logic [AXIS_BITS-1:0]          axis_present;
      logic signed [SW-1:0]          kx_sample;
      logic signed [SW-1:0]          ky_sample;
      logic signed [SW-1:0]          kz_sample;
      logic signed [GAIN_BITS-1:0]   x_gain;
      logic signed [GAIN_BITS-1:0]   y_gain;
      logic signed [GAIN_BITS-1:0]   z_gain;
   } traj_req_type;

   logic clock;
   logic reset;
   int   results_due;
   int   mismatch_count;
   int   cycle_count;

   // Idle switches for the sender and the receiver; they change per stretch of items.
   logic send_idling;
   logic recv_idling;

   // Stimulus bookkeeping. A rotated sample may only name a matrix whose nine
   // coefficients have all been written, so every written slot is remembered.
   int                  items_sent;
   int                  n_loads;
   int                  n_samples;
   int                  n_rotated;
   int                  n_closes;
   int                  n_dropped;
   logic [MAT_SIZE-1:0] coef_loaded [ROT_ENTRIES_DEF];
   int                  full_entries [$];

   kts_req_if req_chan ();
   kts_rsp_if rsp_chan ();

   kspace_trajectory_scale_rotate u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   kts_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .results_due    (results_due),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that has not finished by the limit has hung somewhere.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver back-pressure. While recv_idling is set, ready is now and then held low
   // for a burst; otherwise it stays high. Every change happens at a falling edge, one
   // assignment per edge.
   initial begin : ready_drive
      int stall_len;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_idling && $urandom_range(0, 5) == 0) begin
            stall_len = int'($urandom_range(1, 13));
            rsp_chan.ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // A field value from one of several classes: zero, either extreme, values near a
   // typical magnitude, or anything at all that the width allows.
   function automatic int pick_value(int bits, int unit);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return (1 <<< (bits - 1)) - 1;
         2: return -(1 <<< (bits - 1));
         3, 4, 5: return int'($urandom_range(0, 2 * unit)) - unit;
         default: return int'($urandom()) >>> (32 - bits);
      endcase
   endfunction

   // Fields that an operation ignores still carry random bits, so the block is
   // also seen to ignore them.
   function automatic traj_req_type random_fill();
      traj_req_type it;
      it.op           = OP_SAMPLE;
      it.rot_index    = ROT_IDX_BITS'($urandom());
      it.coef_index   = COEF_IDX_BITS'($urandom());
      it.coef_value   = CW'($urandom());
      it.rotate       = 1'b0;
      it.axis_present = AXIS_BITS'($urandom());
      it.kx_sample    = SW'($urandom());
      it.ky_sample    = SW'($urandom());
      it.kz_sample    = SW'($urandom());
      it.x_gain       = GAIN_BITS'($urandom());
      it.y_gain       = GAIN_BITS'($urandom());
      it.z_gain       = GAIN_BITS'($urandom());
      return it;
   endfunction

   // Presents one item and holds it until the block takes it. The caller is always
   // at a falling edge, and so is this task when it returns. A sender gap, when one
   // is drawn, lowers valid first and raises it a number of edges later, so valid
   // never gets two assignments in one time step.
   task automatic push_item(input traj_req_type it);
      int gap;
      if (send_idling && $urandom_range(0, 4) == 0) begin
         gap = int'($urandom_range(1, 13));
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= it.op;
      req_chan.rot_index    <= it.rot_index;
      req_chan.coef_index   <= it.coef_index;
      req_chan.coef_value   <= it.coef_value;
      req_chan.rotate       <= it.rotate;
      req_chan.axis_present <= it.axis_present;
      req_chan.kx_sample    <= it.kx_sample;
      req_chan.ky_sample    <= it.ky_sample;
      req_chan.kz_sample    <= it.kz_sample;
      req_chan.x_gain       <= it.x_gain;
      req_chan.y_gain       <= it.y_gain;
      req_chan.z_gain       <= it.z_gain;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted result has been taken.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
   endtask

   // A coefficient load. A slot above 8 is dropped by the block, so it neither
   // counts as a load nor marks anything as written.
   task automatic send_load(int entry, int pos, int value);
      traj_req_type it;
      logic         was_full;
      it            = random_fill();
      it.op         = OP_LOAD;
      it.rot_index  = ROT_IDX_BITS'(entry);
      it.coef_index = COEF_IDX_BITS'(pos);
      it.coef_value = CW'(value);
      push_item(it);
      if (pos < MAT_SIZE) begin
         n_loads++;
         items_sent++;
         was_full = &coef_loaded[entry];
         coef_loaded[entry][pos] = 1'b1;
         if (!was_full && &coef_loaded[entry]) full_entries = {full_entries, entry};
      end else begin
         n_dropped++;
      end
   endtask

   task automatic load_matrix(int entry);
      for (int pos = 0; pos < MAT_SIZE; pos++) begin
         send_load(entry, pos, pick_value(CW, COEF_ONE));
      end
   endtask

   task automatic send_sample(logic rot_on, int entry, logic [AXIS_BITS-1:0] present,
                              int kx, int ky, int kz, int gx, int gy, int gz);
      traj_req_type it;
      it              = random_fill();
      it.op           = OP_SAMPLE;
      it.rotate       = rot_on;
      it.rot_index    = ROT_IDX_BITS'(entry);
      it.axis_present = present;
      it.kx_sample    = SW'(kx);
      it.ky_sample    = SW'(ky);
      it.kz_sample    = SW'(kz);
      it.x_gain       = GAIN_BITS'(gx);
      it.y_gain       = GAIN_BITS'(gy);
      it.z_gain       = GAIN_BITS'(gz);
      push_item(it);
      n_samples++;
      items_sent++;
      if (rot_on) n_rotated++;
   endtask

   // Most random samples rotate through a fully loaded matrix; the rest pass the
   // scaled axes straight through, with whatever index they happen to carry.
   task automatic send_random_sample();
      logic                 rot_on;
      int                   entry;
      logic [AXIS_BITS-1:0] present;
      rot_on = 1'b0;
      entry  = int'($urandom_range(0, ROT_ENTRIES_DEF - 1));
      if (full_entries.size() > 0 && $urandom_range(0, 3) != 0) begin
         rot_on = 1'b1;
         entry  = full_entries[$urandom_range(0, full_entries.size() - 1)];
      end
      present = ($urandom_range(0, 2) == 0) ? AXIS_BITS'($urandom()) : '1;
      send_sample(rot_on, entry, present,
                  pick_value(SW, 4096), pick_value(SW, 4096), pick_value(SW, 4096),
                  pick_value(GAIN_BITS, GAIN_ONE), pick_value(GAIN_BITS, GAIN_ONE),
                  pick_value(GAIN_BITS, GAIN_ONE));
   endtask

   task automatic send_close();
      traj_req_type it;
      it    = random_fill();
      it.op = OP_CLOSE;
      push_item(it);
      n_closes++;
      items_sent++;
   endtask

   task automatic send_unused();
      traj_req_type it;
      it    = random_fill();
      it.op = OP_UNUSED;
      push_item(it);
      n_dropped++;
   endtask

   initial begin : stimulus
      int         pick;
      int         stop_at;
      int         calm_from;
      int         mode_until;
      int         next_drain;
      logic [1:0] mode;

      // Every input is known from time zero, while reset is held.
      reset                 = 1'b1;
      send_idling           = 1'b1;
      recv_idling           = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.op           = OP_LOAD;
      req_chan.rot_index    = '0;
      req_chan.coef_index   = '0;
      req_chan.coef_value   = '0;
      req_chan.rotate       = 1'b0;
      req_chan.axis_present = '0;
      req_chan.kx_sample    = '0;
      req_chan.ky_sample    = '0;
      req_chan.kz_sample    = '0;
      req_chan.x_gain       = '0;
      req_chan.y_gain       = '0;
      req_chan.z_gain       = '0;
      items_sent = 0;
      n_loads    = 0;
      n_samples  = 0;
      n_rotated  = 0;
      n_closes   = 0;
      n_dropped  = 0;
      for (int e = 0; e < ROT_ENTRIES_DEF; e++) coef_loaded[e] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- Directed part ----
      // A close straight after reset must report an empty axis mask.
      send_close();

      // The last table entry gets a matrix of alternating coefficient extremes.
      // A load to a slot beyond the matrix follows; it must leave the entry alone.
      for (int pos = 0; pos < MAT_SIZE; pos++) begin
         send_load(ROT_ENTRIES_DEF - 1, pos, (pos % 2 == 0) ? C_MAX : C_MIN);
      end
      send_load(ROT_ENTRIES_DEF - 1, (1 << COEF_IDX_BITS) - 1, 0);

      // The unused operation code gives nothing back.
      send_unused();

      // Unrotated samples at the field extremes: each of these saturates, upward
      // and downward, while the third sample hits the rounding midpoint on x
      // (rounds up to 1) and on y (rounds up to 0), with z absent though nonzero.
      send_sample(1'b0, 0, 3'b111, S_MAX, S_MAX, S_MAX, G_MAX, G_MAX, G_MAX);
      send_sample(1'b0, 0, 3'b111, S_MIN, S_MIN, 0, G_MIN, G_MAX, G_MAX);
      send_sample(1'b0, 0, 3'b011, 1, -1, S_MAX, GAIN_ONE / 2, GAIN_ONE / 2, G_MAX);
      send_close();

      // Rotation through the extreme matrix: moderate values that stay in range,
      // full-scale values that saturate, and a sample with every axis absent.
      send_sample(1'b1, ROT_ENTRIES_DEF - 1, 3'b111, 1000, -2000, 3000,
                  GAIN_ONE, GAIN_ONE, GAIN_ONE);
      send_sample(1'b1, ROT_ENTRIES_DEF - 1, 3'b111, S_MAX, S_MIN, S_MAX,
                  G_MAX, G_MAX, G_MIN);
      send_sample(1'b1, ROT_ENTRIES_DEF - 1, 3'b000, S_MAX, S_MAX, S_MAX,
                  G_MAX, G_MAX, G_MAX);
      send_close();

      // Only y produces a nonzero value; zero gains make the next sample all zero,
      // so the report must show y alone.
      send_sample(1'b0, 5, 3'b010, 7, -5000, 9, -GAIN_ONE, -GAIN_ONE, -GAIN_ONE);
      send_sample(1'b0, 5, 3'b111, S_MAX, S_MIN, 1234, 0, 0, 0);
      send_close();

      // ---- Random part ----
      // Stretches of items alternate between idle patterns: none, sender only,
      // receiver only, both. The last stretch runs without any idling, and every
      // DRAIN_SPAN items the sender holds off until all results are back.
      stop_at    = items_sent + ITEM_TARGET;
      calm_from  = stop_at - CALM_TAIL;
      mode_until = items_sent;
      next_drain = items_sent + DRAIN_SPAN;
      while (items_sent < stop_at) begin
         if (items_sent >= mode_until) begin
            if (items_sent >= calm_from) begin
               send_idling = 1'b0;
               recv_idling = 1'b0;
               mode_until  = stop_at;
            end else begin
               mode        = 2'($urandom_range(0, 3));
               send_idling = mode[0];
               recv_idling = mode[1];
               mode_until  = items_sent + MODE_SPAN;
               if (mode_until > calm_from) mode_until = calm_from;
            end
         end
         if (items_sent >= next_drain) begin
            wait_for_results();
            next_drain += DRAIN_SPAN;
         end

         pick = int'($urandom_range(0, 99));
         if (pick < 10) begin
            load_matrix(int'($urandom_range(0, ROT_ENTRIES_DEF - 1)));
         end else if (pick < 15) begin
            // A lone coefficient update, possibly into a matrix not yet complete.
            send_load(int'($urandom_range(0, ROT_ENTRIES_DEF - 1)),
                      int'($urandom_range(0, MAT_SIZE - 1)), pick_value(CW, COEF_ONE));
         end else if (pick < 18) begin
            send_load(int'($urandom_range(0, ROT_ENTRIES_DEF - 1)),
                      int'($urandom_range(MAT_SIZE, (1 << COEF_IDX_BITS) - 1)),
                      int'($urandom()));
         end else if (pick < 20) begin
            send_unused();
         end else if (pick < 28) begin
            send_close();
         end else begin
            send_random_sample();
         end
      end

      // Let everything drain, then give the block time to show any stray result.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d coefficient loads filling %0d table entries, %0d samples (%0d rotated)",
               n_loads, full_entries.size(), n_samples, n_rotated);
      $display("and %0d closes, plus %0d items the block should drop, in %0d cycles.",
               n_closes, n_dropped, cycle_count);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ kspace_trajectory_scale_rotate.f @@
rtl/kts_pkg.sv
rtl/kts_channels.sv
rtl/kts_ram.sv
rtl/kts_front.sv
rtl/kts_back.sv
rtl/kspace_trajectory_scale_rotate.sv
rtl/kts_checker.sv
dv/kts_checker.sv
dv/kspace_trajectory_scale_rotate_tb.sv
